// File: rtl/wade_pkg.sv
// Shared constants and types for the windowed average density estimator.
package wade_pkg;

   localparam int WINDOW_SIZE   = 25;
   localparam int SAMPLE_W      = 16;
   localparam int AVG_W         = 16;
   localparam int EST_W         = 14;
   localparam int FILL_VALUE    = 1000;
   localparam int DENSITY_SCALE = 10000;
   localparam int REJECT_RESET  = 10000;

   localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int SUM_W  = $clog2(WINDOW_SIZE * 65535 + 1);

   // Division of the running sum by the window size is done as a
   // multiplication by a rounded-up reciprocal followed by a shift.
   localparam int    RECIP_SHIFT = SUM_W + $clog2(WINDOW_SIZE) + 1;
   localparam int    RECIP_W     = RECIP_SHIFT + 1 - $clog2(WINDOW_SIZE);
   localparam longint RECIP_VALUE =
      ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_SIZE) - 1) / longint'(WINDOW_SIZE);
   localparam int    PROD_W      = SUM_W + RECIP_W;

   // Restoring divider for the density quotient.
   localparam int DIV_STEPS = EST_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SCALE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

// File: rtl/windowed_average_density_estimator.sv
// Top level of the windowed average density estimator.
//
// One sample item enters on the req_ channel (req_valid, req_stall,
// req_sample) and one result item leaves on the rsp_ channel (rsp_valid,
// rsp_stall, rsp_accepted, rsp_average, rsp_estimate). An item moves at a
// rising edge where valid is high and stall is low on that channel.
// The reject limit is written through csr_valid, csr_ready and csr_data;
// csr_ready is always high, and writes are expected only while idle.
//
// After acceptance a kept sample passes through these states in order: ST_SUM
// updates the ring and sum, ST_SCALE runs the reciprocal multiply for the
// average, ST_DIVIDE drives the shared restoring subtractor for 10000 / average
// and ST_DONE loads the output register. A rejected sample skips the update.
// The next item is taken in the cycle after the load, so the block takes no
// new item until the result of the last one has been loaded.
// Reset clears the ring's valid bits so every entry reads as 1000, and
// returns the sum to the window size times 1000 and the limit to 10000. If
// the receiver stalls, the result waits in the output register while the next
// item is accepted and worked on, parking in its final state until it is free.
module windowed_average_density_estimator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [wade_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_accepted,
   output logic [wade_pkg::AVG_W-1:0]     rsp_average,
   output logic [wade_pkg::EST_W-1:0]     rsp_estimate,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [wade_pkg::SAMPLE_W-1:0]  csr_data
);
   import wade_pkg::*;

   localparam logic [SUM_W-1:0]    SUM_RESET = SUM_W'(WINDOW_SIZE * FILL_VALUE);
   localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);
   localparam logic [RECIP_W-1:0]  RECIP     = RECIP_W'(RECIP_VALUE);
   localparam logic [EST_W-1:0]    DIVIDEND  = EST_W'(DENSITY_SCALE);
   localparam logic [CNT_W-1:0]    LAST_STEP = CNT_W'(DIV_STEPS - 1);

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0]    reject_ff;
   logic [SAMPLE_W-1:0]    sample_ff;
   logic [SAMPLE_W-1:0]    old_ff;
   logic                   take_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [WINDOW_SIZE-1:0] filled_ff;
   logic [SAMPLE_W-1:0]    store_ff [WINDOW_SIZE];
   logic [AVG_W-1:0]       avg_ff, avg_in;
   logic [AVG_W-1:0]       rem_ff, rem_in;
   logic [EST_W-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]       step_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_accepted_ff;
   logic [AVG_W-1:0]       rsp_average_ff;
   logic [EST_W-1:0]       rsp_estimate_ff;

   logic                   req_take;
   logic                   out_free;
   logic                   load_out;
   logic [PROD_W-1:0]      product;
   logic [AVG_W-1:0]       divisor;
   logic [AVG_W:0]         trial;
   logic [AVG_W:0]         diff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ((req_sample != '0) && (req_sample <= reject_ff)) ?
                          ST_SUM : ST_SCALE;
            end
         end
         ST_SUM:    state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control outputs
   always_comb begin
      req_stall = 1'b1;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_DONE:  load_out  = out_free;
         default: begin
            req_stall = 1'b1;
            load_out  = 1'b0;
         end
      endcase
   end

   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      sum_in  = sum_ff;
      slot_in = slot_ff;
      if (state_ff == ST_SUM) begin
         sum_in  = sum_ff - SUM_W'(old_ff) + SUM_W'(sample_ff);
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
      end
   end

   assign product = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign avg_in  = product[RECIP_SHIFT +: AVG_W];

   // The average is never zero in practice; treating zero as one keeps the
   // divider defined.
   assign divisor = (avg_ff == '0) ? AVG_W'(1) : avg_ff;
   assign trial   = {rem_ff, quo_ff[EST_W-1]};
   assign diff    = trial - {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (state_ff == ST_SCALE) begin
         rem_in = '0;
         quo_in = DIVIDEND;
      end else if (state_ff == ST_DIVIDE) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[AVG_W-1:0];
            quo_in = {quo_ff[EST_W-2:0], 1'b1};
         end else begin
            rem_in = trial[AVG_W-1:0];
            quo_in = {quo_ff[EST_W-2:0], 1'b0};
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         reject_ff <= SAMPLE_W'(REJECT_RESET);
         sum_ff    <= SUM_RESET;
         slot_ff   <= '0;
         filled_ff <= '0;
         step_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         slot_ff  <= slot_in;
         if (csr_valid && csr_ready) begin
            reject_ff <= csr_data;
         end
         if (state_ff == ST_SUM) begin
            filled_ff[slot_ff] <= 1'b1;
         end
         if (state_ff == ST_DIVIDE) begin
            step_ff <= (step_ff == LAST_STEP) ? '0 : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_sample;
         take_ff   <= (req_sample != '0) && (req_sample <= reject_ff);
         // An entry that has not been written since reset still holds the
         // fill value.
         old_ff    <= filled_ff[slot_ff] ? store_ff[slot_ff] : SAMPLE_W'(FILL_VALUE);
      end
      if (state_ff == ST_SUM) begin
         store_ff[slot_ff] <= sample_ff;
      end
      if (state_ff == ST_SCALE) begin
         avg_ff <= avg_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_accepted_ff <= take_ff;
         rsp_average_ff  <= take_ff ? avg_ff : '0;
         rsp_estimate_ff <= (quo_ff == '0) ? '0 : quo_ff - 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_average  = rsp_average_ff;
   assign rsp_estimate = rsp_estimate_ff;

   // ---------------------------------------------------------------- assertions
   // Every entry is at least one, so the sum never drops below the window size.
   assert property (@(posedge clock) disable iff (reset)
      sum_ff >= SUM_W'(WINDOW_SIZE))
      else $error("running sum below window size");

   assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("write slot out of range");

   // A new result only appears out of the final state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final state");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_average == '0))
      else $error("rejected sample reports a non-zero average");

endmodule

// File: sim/windowed_average_density_estimator_test.sv
// Self-checking testbench for the windowed average density estimator.
`timescale 1ns / 100ps

module windowed_average_density_estimator_test;
   import wade_pkg::*;

   // One result item as the block presents it on the rsp_ channel.
   typedef struct packed {
      logic             accepted;
      logic [AVG_W-1:0] average;
      logic [EST_W-1:0] estimate;
   } window_result_type;

   // Every input is given a known value from time zero. Reset is high
   // from the start and is released once, at a falling edge.
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_accepted;
   logic [AVG_W-1:0]    rsp_average;
   logic [EST_W-1:0]    rsp_estimate;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SAMPLE_W-1:0] csr_data  = '0;

   // Our own copy of the window: the ring of recent samples, the slot
   // that the next kept sample overwrites, the running sum and the
   // reject limit as last written.
   logic [SAMPLE_W-1:0] ring [WINDOW_SIZE];
   logic [SLOT_W-1:0]   ring_slot;
   logic [SUM_W-1:0]    ring_sum;
   logic [SAMPLE_W-1:0] reject_limit;

   // Samples waiting to be offered, and results owed by the block in
   // the order that their samples were taken.
   logic [SAMPLE_W-1:0] sample_queue [$];
   window_result_type   awaited_results [$];

   int unsigned samples_issued  = 0;
   int unsigned samples_taken   = 0;
   int unsigned results_checked = 0;
   int unsigned kept_count      = 0;
   int unsigned zero_estimates  = 0;
   int unsigned top_estimates   = 0;
   int unsigned limits_written  = 0;
   int unsigned input_stalls    = 0;
   int unsigned failures        = 0;

   // Set at each rising edge when a sample item was taken, so that the
   // driver knows at the following falling edge that it may move on.
   bit req_took    = 1'b0;
   // Random idling on both sides is on in a random phase unless it asks for a quiet run.
   bit idling      = 1'b0;
   // The phase that wants the receiver to hold off for a long while.
   bit hold_wanted = 1'b0;
   bit hold_started = 1'b0;
   int send_gap    = 0;
   int stall_left  = 0;
   int hold_left   = 0;

   windowed_average_density_estimator dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_accepted (rsp_accepted),
      .rsp_average  (rsp_average),
      .rsp_estimate (rsp_estimate),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one sample to our copy of the window and works out the
   // result item that the block must give for it. A zero sample, or one
   // above the limit, leaves the window alone; the average field then
   // reads 0 but the estimate still comes from the unchanged window.
   function automatic window_result_type window_update(input logic [SAMPLE_W-1:0] s);
      window_result_type r;
      int unsigned       mean;
      int unsigned       divisor;
      int unsigned       quotient;
      logic              take;
      take = (s != '0) && (s <= reject_limit);
      if (take) begin
         ring_sum = ring_sum - ring[ring_slot] + s;
         ring[ring_slot] = s;
         ring_slot = (ring_slot == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : ring_slot + 1'b1;
      end
      mean = ring_sum / WINDOW_SIZE;
      // Every entry is at least 1, so the mean cannot be zero; treat it
      // as 1 all the same rather than divide by zero.
      divisor = (mean == 0) ? 1 : mean;
      quotient = DENSITY_SCALE / divisor;
      r.accepted = take;
      r.average  = take ? AVG_W'(mean) : '0;
      // A mean above the density scale gives a zero quotient, and the
      // estimate then sticks at zero instead of wrapping round.
      r.estimate = (quotient == 0) ? '0 : EST_W'(quotient - 1);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Random samples lean towards the kept range, with zeros, values over the
   // limit, the limit itself and the full 16-bit range mixed in.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] limit);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return '0;
      if (roll < 12) return SAMPLE_W'($urandom_range(0, 65535));
      if (roll < 20 && limit != '1) return SAMPLE_W'($urandom_range(int'(limit) + 1, 65535));
      if (roll < 28) return limit;
      if (roll < 32) return SAMPLE_W'(1);
      return SAMPLE_W'($urandom_range(1, int'(limit)));
   endfunction

   // Prediction and checking. Both happen at the rising edge, where the
   // inputs have been steady since the previous falling edge and the
   // block's outputs still hold their values from before the edge.
   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         for (int i = 0; i < WINDOW_SIZE; i++) ring[i] = SAMPLE_W'(FILL_VALUE);
         ring_slot    = '0;
         ring_sum     = SUM_W'(WINDOW_SIZE * FILL_VALUE);
         reject_limit = SAMPLE_W'(REJECT_RESET);
         awaited_results.delete();
         req_took = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            reject_limit = csr_data;
            limits_written++;
         end
         if (req_valid && req_stall) input_stalls++;
         req_took = req_valid && !req_stall;
         if (req_took) begin
            awaited_results.push_back(window_update(req_sample));
            samples_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
               $error("result item with nothing awaited: accepted %0d, average %0d, estimate %0d",
                      rsp_accepted, rsp_average, rsp_estimate);
               failures++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_accepted);
                  failures++;
               end
               if (rsp_average !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_average);
                  failures++;
               end
               if (rsp_estimate !== want.estimate) begin
                  $error("estimate: expected %0d, got %0d", want.estimate, rsp_estimate);
                  failures++;
               end
            end
            if (rsp_accepted === 1'b1) kept_count++;
            if (rsp_estimate === '0) zero_estimates++;
            if (rsp_estimate === EST_W'(DENSITY_SCALE - 1)) top_estimates++;
         end
      end
   end

   // Sender. A payload is held until the block takes it; after each item
   // taken it may go quiet for a while before offering the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            req_sample <= sample_queue.pop_front();
            req_valid  <= 1'b1;
            send_gap = idling ? idle_span() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Besides the short random stalls there is one long
   // hold-off, counted here, while the sender keeps offering samples:
   // the block then has a finished result parked and a second one
   // waiting behind it, and has to push back on its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_wanted && !hold_started) begin
         hold_started = 1'b1;
         hold_left = 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (idling) stall_left = idle_span();
      end
   end

   task automatic offer(input logic [SAMPLE_W-1:0] s);
      sample_queue.push_back(s);
      samples_issued++;
   endtask

   // Waits until every sample has been taken and every result has come
   // back. Each sample gives exactly one result, so the block is idle then.
   task automatic drain();
      do @(negedge clock);
      while (sample_queue.size() != 0 || samples_taken != samples_issued ||
             awaited_results.size() != 0);
   endtask

   task automatic write_limit(input logic [SAMPLE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random phase: a new limit, then a run of samples shaped by it.
   task automatic run_phase(input logic [SAMPLE_W-1:0] limit, input int count,
                            input bit quiet, input bit squeeze);
      write_limit(limit);
      idling = !quiet;
      hold_wanted = squeeze;
      for (int n = 0; n < count; n++) offer(pick_sample(limit));
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed samples under the reset limit: zero, just over the limit,
      // the largest sample, the limit itself, the smallest kept sample and
      // alternating bit patterns, both of them over the limit.
      offer(16'd0);
      offer(16'd10001);
      offer(16'hFFFF);
      offer(16'd10000);
      offer(16'd1);
      offer(16'd9999);
      offer(16'h5555);
      offer(16'hAAAA);
      offer(16'd1000);
      drain();

      // With the widest limit a few of the largest samples push the mean
      // above the density scale, so the estimate has to stick at zero.
      write_limit(16'hFFFF);
      repeat (5) offer(16'hFFFF);
      offer(16'hAAAA);
      offer(16'h5555);
      offer(16'd0);
      drain();

      // A limit of zero turns every sample away.
      write_limit(16'd0);
      offer(16'd1);
      offer(16'hFFFF);
      offer(16'd500);
      drain();

      // Random phases. With a limit of 1 the window fills with ones and
      // the estimate reaches its top value; the quiet phase runs with no
      // idling at all, and the squeezed one carries the long hold-off.
      run_phase(16'd1, 220, 1'b0, 1'b0);
      run_phase(16'hFFFF, 220, 1'b0, 1'b0);
      run_phase(16'd200, 220, 1'b0, 1'b0);
      run_phase(SAMPLE_W'($urandom_range(1, 65535)), 220, 1'b0, 1'b0);
      run_phase(16'd10000, 220, 1'b1, 1'b0);
      run_phase(SAMPLE_W'($urandom_range(1, 500)), 220, 1'b0, 1'b0);
      run_phase(16'd30000, 220, 1'b0, 1'b1);
      run_phase(16'd5000, 220, 1'b0, 1'b0);

      // Leave room for any stray result to show up before judging.
      repeat (25) @(posedge clock);

      $display("Checked %0d results: %0d samples kept, %0d zero estimates, %0d at the top.",
               results_checked, kept_count, zero_estimates, top_estimates);
      $display("Limit written %0d times; input held off by the block for %0d cycles.",
               limits_written, input_stalls);
      if (failures == 0) begin
         $display("** windowed_average_density_estimator: PASSED **");
      end else begin
         $display("** windowed_average_density_estimator: FAILED **");
      end
      $finish;
   end

   // Well beyond the slowest correct run, including every gap and stall.
   initial begin
      #7_000_000;
      $display("Timed out with %0d results still awaited.", awaited_results.size());
      $display("** windowed_average_density_estimator: FAILED **");
      $finish;
   end

endmodule
